// ===== sv/fqdm_pkg.sv =====
// Shared types, constants and helpers for the FIFO queue with delete-min.
// Used by the cell, the controller and the top level; depends on nothing.
package fqdm_pkg;

	localparam int DEPTH   = 128;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 8;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [CMD_W-1:0]        cmd_t;

	localparam cmd_t CMD_ENQ    = 2'd0;
	localparam cmd_t CMD_DEQ    = 2'd1;
	localparam cmd_t CMD_DELMIN = 2'd2;

	localparam val_t INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		idx_t     sel;
	} cell_ctrl_t;

	typedef struct packed {
		val_t                value;
		status_t             status;
		logic [COUNT_W-1:0]  count;
	} result_t;

	function automatic logic [COUNT_W-1:0] count_field(cnt_t c);
		logic [CNT_W+COUNT_W-1:0] w;
		w = {{COUNT_W{1'b0}}, c};
		return w[COUNT_W-1:0];
	endfunction

endpackage

// ===== sv/fqdm_cell.sv =====
// One storage cell of the queue chain: holds one entry, loads, shifts or rotates.
// Depends on fqdm_pkg.
module fqdm_cell (
	input  logic               clk,
	input  fqdm_pkg::cell_ctrl_t ctrl,
	input  fqdm_pkg::idx_t     cell_idx,
	input  fqdm_pkg::val_t     bcast,
	input  fqdm_pkg::val_t     nxt,
	output fqdm_pkg::val_t     data
);
	import fqdm_pkg::*;

	val_t data_q;
	val_t data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			CELL_HOLD: data_d = data_q;
			CELL_LOAD: begin
				if (cell_idx == ctrl.sel) data_d = bcast;
			end
			CELL_SHIFT: begin
				if (cell_idx >= ctrl.sel) data_d = nxt;
			end
			CELL_ROTATE: begin
				data_d = (cell_idx == ctrl.sel) ? bcast : nxt;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ===== sv/fqdm_ctrl.sv =====
// Controller: request handshake, count, min scan, chain commands, result registers.
// Depends on fqdm_pkg; drives the row of fqdm_cell instances.
module fqdm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           cmd,
	input  logic signed [31:0]   push_value,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic signed [31:0]   out_value,
	output logic [1:0]           status,
	output logic [7:0]           count,
	input  fqdm_pkg::val_t       head_value,
	output fqdm_pkg::cell_ctrl_t cell_ctrl,
	output fqdm_pkg::val_t       bcast
);
	import fqdm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMPACT
	} state_t;

	state_t  state_q, state_d;
	cnt_t    count_q, count_d;
	cnt_t    scan_q;
	val_t    min_q;
	idx_t    min_pos_q;
	result_t out_q, spare_q, res;
	logic    out_valid_q, spare_valid_q;
	logic    accept, done, out_take;
	idx_t    last_idx;

	assign req_stall = (state_q != S_IDLE) || spare_valid_q;
	assign accept    = req_valid && !req_stall;
	assign out_take  = out_valid_q && !res_stall;
	assign last_idx  = idx_t'(count_q - cnt_t'(1));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cell_ctrl = '{op: CELL_HOLD, sel: '0};
		bcast     = push_value;
		done      = 1'b0;
		res       = '{value: '0, status: ST_OK, count: count_field(count_q)};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_ENQ: begin
							done = 1'b1;
							if (count_q < cnt_t'(DEPTH)) begin
								cell_ctrl = '{op: CELL_LOAD, sel: count_q[IDX_W-1:0]};
								count_d   = count_q + cnt_t'(1);
								res.count = count_field(count_d);
							end else begin
								res.status = ST_FULL;
							end
						end
						CMD_DEQ: begin
							done = 1'b1;
							if (count_q != '0) begin
								cell_ctrl = '{op: CELL_SHIFT, sel: '0};
								count_d   = count_q - cnt_t'(1);
								res.value = head_value;
								res.count = count_field(count_d);
							end else begin
								res.status = ST_EMPTY;
							end
						end
						CMD_DELMIN: begin
							if (count_q != '0) begin
								state_d = S_SCAN;
							end else begin
								done       = 1'b1;
								res.value  = INT_MAX;
								res.status = ST_EMPTY;
							end
						end
						default: done = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				cell_ctrl = '{op: CELL_ROTATE, sel: last_idx};
				bcast     = head_value;
				if (scan_q == count_q - cnt_t'(1)) state_d = S_COMPACT;
			end
			S_COMPACT: begin
				cell_ctrl = '{op: CELL_SHIFT, sel: min_pos_q};
				count_d   = count_q - cnt_t'(1);
				done      = 1'b1;
				res.value = min_q;
				res.count = count_field(count_d);
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			scan_q        <= '0;
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == S_SCAN) begin
				if (scan_q == '0 || head_value < min_q) begin
					min_q     <= head_value;
					min_pos_q <= scan_q[IDX_W-1:0];
				end
				scan_q <= scan_q + cnt_t'(1);
			end else begin
				scan_q <= '0;
			end
			if (done) begin
				if (!out_valid_q || out_take) begin
					out_q       <= res;
					out_valid_q <= 1'b1;
				end else begin
					spare_q       <= res;
					spare_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				if (spare_valid_q) begin
					out_q         <= spare_q;
					spare_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign res_valid = out_valid_q;
	assign out_value = out_q.value;
	assign status    = out_q.status;
	assign count     = out_q.count;

`ifndef SYNTHESIS
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("spare result held without a result at the output");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0 && scan_q < count_q))
		else $error("scan running past the stored entries");

	a_compact_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT) |=> (state_q == S_IDLE && count_q == $past(count_q) - cnt_t'(1)))
		else $error("compaction did not drop exactly one entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("entry count above depth");
`endif

endmodule

// ===== sv/fifo_queue_with_delete_min.sv =====
// FIFO queue with delete-min: a row of DEPTH cells plus a controller.
// Enqueue and dequeue: result registered on acceptance into the output register, or into a spare
// one while the output stalls; a full spare stalls requests. Delete-min: requests stall while the
// queue rotates once through the cell chain to find the minimum and a shift closes the gap.
// Reset clears count and control; cell contents stay undefined until written.
// Depends on fqdm_pkg, fqdm_cell, fqdm_ctrl.
module fifo_queue_with_delete_min (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          cmd,
	input  logic signed [31:0]  push_value,
	output logic                res_valid,
	input  logic                res_stall,
	output logic signed [31:0]  out_value,
	output logic [1:0]          status,
	output logic [7:0]          count
);
	import fqdm_pkg::*;

	cell_ctrl_t cell_ctrl;
	val_t       bcast;
	val_t       cell_data [DEPTH];
	val_t       cell_nxt  [DEPTH];

	fqdm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (push_value),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_value  (out_value),
		.status     (status),
		.count      (count),
		.head_value (cell_data[0]),
		.cell_ctrl  (cell_ctrl),
		.bcast      (bcast)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_last
			assign cell_nxt[i] = cell_data[i];
		end else begin : g_mid
			assign cell_nxt[i] = cell_data[i+1];
		end

		fqdm_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.cell_idx (idx_t'(i)),
			.bcast    (bcast),
			.nxt      (cell_nxt[i]),
			.data     (cell_data[i])
		);
	end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the FIFO queue with delete-min.
// A queue-based predictor checks every result field by field under random idling on both sides.
// Depends on fqdm_pkg and fifo_queue_with_delete_min.
module testbench;
	import fqdm_pkg::*;

	localparam cmd_t CMD_UNUSED = 2'd3;
	localparam val_t INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct {
		cmd_t op;
		val_t value;
		bit   drain_first;
	} request_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         cmd = CMD_ENQ;
	logic signed [31:0] push_value = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [31:0] out_value;
	logic [1:0]         status;
	logic [7:0]         count;

	request_t pending[$];
	val_t     queue_contents[$];
	result_t  predicted_results[$];
	int       n_accepted = 0;
	int       n_done = 0;
	int       n_errors = 0;
	int       gen_fill = 0;
	int       n_enq = 0, n_full = 0, n_deq = 0, n_delmin = 0, n_unused = 0, n_empty = 0;
	logic     calm;

	assign calm = n_accepted >= 400 && n_accepted < 650;

	fifo_queue_with_delete_min u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t predict_queue_op(cmd_t op, val_t v);
		result_t r;
		int      pos;
		val_t    lowest;
		r.value  = '0;
		r.status = ST_OK;
		case (op)
			CMD_ENQ: begin
				n_enq++;
				if (queue_contents.size() >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					queue_contents.push_back(v);
				end
			end
			CMD_DEQ: begin
				n_deq++;
				if (queue_contents.size() == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					r.value = queue_contents.pop_front();
				end
			end
			CMD_DELMIN: begin
				n_delmin++;
				if (queue_contents.size() == 0) begin
					r.value  = INT_MAX;
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					lowest = queue_contents[0];
					pos    = 0;
					for (int k = 1; k < queue_contents.size(); k++)
						if (queue_contents[k] < lowest) begin
							lowest = queue_contents[k];
							pos    = k;
						end
					queue_contents.delete(pos);
					r.value = lowest;
				end
			end
			default: n_unused++;
		endcase
		r.count = 8'(queue_contents.size());
		return r;
	endfunction

	function automatic val_t pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return val_t'($urandom_range(16)) - 8;
		if (roll < 50)
			case ($urandom_range(3))
				0: return INT_MIN;
				1: return INT_MAX;
				2: return '0;
				default: return '1;
			endcase
		return val_t'($urandom);
	endfunction

	function automatic cmd_t pick_op(int enq_pct);
		int roll;
		if ($urandom_range(99) < enq_pct)
			return CMD_ENQ;
		roll = $urandom_range(99);
		if (roll < 45)
			return CMD_DEQ;
		if (roll < 90)
			return CMD_DELMIN;
		return CMD_UNUSED;
	endfunction

	task automatic add_request(cmd_t op, val_t v, bit drain_first);
		request_t rq;
		rq.op          = op;
		rq.value       = (op == CMD_ENQ) ? v : val_t'($urandom);
		rq.drain_first = drain_first;
		pending.push_back(rq);
		if (op == CMD_ENQ && gen_fill < DEPTH)
			gen_fill++;
		else if ((op == CMD_DEQ || op == CMD_DELMIN) && gen_fill > 0)
			gen_fill--;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		int sent;
		if (!arst_n) begin
			req_valid  <= 1'b0;
			cmd        <= CMD_ENQ;
			push_value <= '0;
			n_accepted <= 0;
		end else begin
			sent = n_accepted;
			if (req_valid && !req_stall) begin
				predicted_results.push_back(predict_queue_op(cmd, push_value));
				sent = n_accepted + 1;
				n_accepted <= sent;
			end
			if (!req_valid || !req_stall) begin
				if (pending.size() == 0 || (!calm && $urandom_range(99) < 29))
					req_valid <= 1'b0;
				else if (pending[0].drain_first && n_done != sent)
					req_valid <= 1'b0;
				else begin
					req_valid  <= 1'b1;
					cmd        <= pending[0].op;
					push_value <= pending[0].value;
					void'(pending.pop_front());
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			n_done    <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (predicted_results.size() == 0) begin
					$error("result with no request outstanding: value %0d status %0d count %0d",
						out_value, status, count);
					n_errors++;
				end else begin
					want = predicted_results.pop_front();
					if (out_value !== want.value) begin
						$error("out_value: expected %0d, got %0d", want.value, out_value);
						n_errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_errors++;
					end
					if (count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, count);
						n_errors++;
					end
				end
				n_done <= n_done + 1;
			end
			res_stall <= !calm && $urandom_range(99) < 29;
		end
	end

	initial begin
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_DELMIN, '0, 1'b0);
		add_request(CMD_UNUSED, '1, 1'b0);
		add_request(CMD_ENQ, INT_MIN, 1'b0);
		add_request(CMD_ENQ, INT_MAX, 1'b0);
		add_request(CMD_ENQ, '0, 1'b0);
		add_request(CMD_ENQ, -1, 1'b0);
		add_request(CMD_ENQ, 7, 1'b0);
		add_request(CMD_ENQ, -1, 1'b0);
		add_request(CMD_ENQ, INT_MIN, 1'b0);
		add_request(CMD_UNUSED, '0, 1'b0);
		add_request(CMD_DELMIN, '0, 1'b0);
		add_request(CMD_DELMIN, '0, 1'b0);
		add_request(CMD_DELMIN, '0, 1'b0);
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_ENQ, 32'sh5555_5555, 1'b0);
		add_request(CMD_ENQ, 32'shAAAA_AAAA, 1'b0);
		add_request(CMD_DELMIN, '0, 1'b0);
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_DEQ, '0, 1'b0);
		add_request(CMD_DELMIN, '0, 1'b0);
		repeat (2) begin
			add_request(CMD_ENQ, pick_value(), 1'b1);
			while (gen_fill < DEPTH)
				add_request(pick_op(85), pick_value(), 1'b0);
			repeat ($urandom_range(5, 2))
				add_request(CMD_ENQ, pick_value(), 1'b0);
			repeat ($urandom_range(120, 40))
				add_request(pick_op(50), pick_value(), 1'b0);
			add_request(CMD_DELMIN, '0, 1'b1);
			while (gen_fill > 0)
				add_request(pick_op(15), pick_value(), 1'b0);
			repeat ($urandom_range(3, 1))
				add_request(pick_op(0), '0, 1'b0);
			repeat ($urandom_range(120, 40))
				add_request(pick_op(55), pick_value(), 1'b0);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req_valid)
			@(posedge clk);
		while (n_done != n_accepted)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("Ran %0d enqueues (%0d refused as full), %0d dequeues, %0d delete-min, %0d unused",
			n_enq, n_full, n_deq, n_delmin, n_unused);
		$display("commands; %0d requests met an empty queue, %0d results checked.", n_empty, n_done);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
